// File: rtl/ahs_pkg.sv
// ahs_pkg: types, constants and permutation functions for the hash sponge
// used by ascon_hash_sponge_top; no dependencies
package ahs_pkg;

  localparam int ROUND_COUNT  = 12;
  localparam int DIGEST_WORDS = 4;
  localparam int WORD_W       = 64;
  localparam int WCNT_W       = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

  // word 0 sits in the lowest 64 bits
  typedef logic [4:0][WORD_W-1:0] state_t;

  localparam state_t INIT_STATE = {
    64'h348fa5c9d525e140,
    64'h43189921b8f8e3e8,
    64'hb48a92db98d5da62,
    64'h8bb21831c60f1002,
    64'hee9398aadb67f03d
  };

  localparam logic [WORD_W-1:0] PAD_BYTE_TOP = 64'h8000_0000_0000_0000;
  localparam logic [3:0]        RC_HIGH_BASE = 4'hf;

  function automatic logic [WORD_W-1:0] rotr64(input logic [WORD_W-1:0] v, input int n);
    rotr64 = (v >> n) | (v << (WORD_W - n));
  endfunction

  // one round: constant add, s-box layer, linear layer
  function automatic state_t ascon_round(input state_t s, input logic [3:0] r);
    logic [WORD_W-1:0] a, b, c, d, e;
    logic [WORD_W-1:0] t0, t1, t2, t3, t4;
    a = s[0]; b = s[1]; c = s[2]; d = s[3]; e = s[4];
    c = c ^ {56'd0, RC_HIGH_BASE - r, r};
    a = a ^ e; e = e ^ d; c = c ^ b;
    t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
    a = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
    b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
    a = a ^ rotr64(a, 19) ^ rotr64(a, 28);
    b = b ^ rotr64(b, 61) ^ rotr64(b, 39);
    c = c ^ rotr64(c, 1)  ^ rotr64(c, 6);
    d = d ^ rotr64(d, 10) ^ rotr64(d, 17);
    e = e ^ rotr64(e, 7)  ^ rotr64(e, 41);
    ascon_round = {e, d, c, b, a};
  endfunction

  // full permutation, last ROUND_COUNT rounds of the twelve
  function automatic state_t ascon_permute(input state_t s);
    state_t x;
    x = s;
    for (int r = 12 - ROUND_COUNT; r < 12; r++) begin
      x = ascon_round(x, r[3:0]);
    end
    ascon_permute = x;
  endfunction

  // keep the valid leading bytes and put 0x80 right after them
  function automatic logic [WORD_W-1:0] pad_block(input logic [WORD_W-1:0] blk,
                                                   input logic [2:0] nv);
    logic [5:0]        sh;
    logic [WORD_W-1:0] keep;
    sh   = {nv, 3'b000};
    keep = ~({WORD_W{1'b1}} >> sh);
    pad_block = (blk & keep) | (PAD_BYTE_TOP >> sh);
  endfunction

endpackage

// File: rtl/ascon_hash_sponge_top.sv
// ascon_hash_sponge_top: hash sponge with a combinational 12-round permutation
// depends on ahs_pkg (state type, initial value, permutation and padding)
//
//   channel | dir | tdata                              | tlast
//   s_      | in  | [63:0] block, [66:64] valid_bytes  | final_block
//   m_      | out | [63:0] digest_word                 | digest_last
//
// a non-final block is absorbed and permuted into the state register, one beat per cycle while not squeezing
// a final block is absorbed into the state register, then the four digest words leave
// one per cycle through the shared permutation; s_tready is low while squeezing
// a stall on m_ holds the squeeze; the output register frees the input side
// reset loads the initial value into the state and empties the output register
module ascon_hash_sponge_top
  import ahs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [63:0] block, [66:64] valid_bytes, zeros above
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] digest_word
  output logic        m_tlast
);

  localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(DIGEST_WORDS - 1);

  state_t              st;
  state_t              st_next;
  state_t              perm_in;
  state_t              perm_out;
  logic                squeezing;
  logic [WCNT_W-1:0]   wcnt;
  logic                in_beat;
  logic                out_free;
  logic                sq_step;
  logic                sq_last;
  logic [WORD_W-1:0]   absorb_word;

  // handshake terms
  assign s_tready = !squeezing;
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sq_step  = squeezing && out_free;
  assign sq_last  = (wcnt == LAST_WORD);

  // absorb word, padded on a final beat
  assign absorb_word = s_tlast ? pad_block(s_tdata[63:0], s_tdata[66:64]) : s_tdata[63:0];

  // shared permutation: absorb path or squeeze path
  always_comb begin
    perm_in = st;
    if (!squeezing) begin
      perm_in[0] = st[0] ^ absorb_word;
    end
  end

  assign perm_out = ascon_permute(perm_in);

  // next sponge state
  always_comb begin
    priority if (in_beat) begin
      st_next = perm_out;
    end else if (sq_step) begin
      st_next = sq_last ? INIT_STATE : perm_out;
    end else begin
      st_next = st;
    end
  end

  // state and squeeze control
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= INIT_STATE;
      squeezing <= 1'b0;
      wcnt      <= '0;
    end else begin
      st <= st_next;
      if (in_beat && s_tlast) begin
        squeezing <= 1'b1;
        wcnt      <= '0;
      end else if (sq_step) begin
        if (sq_last) begin
          squeezing <= 1'b0;
          wcnt      <= '0;
        end else begin
          wcnt <= wcnt + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sq_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_step) begin
      m_tdata <= st[0];
      m_tlast <= sq_last;
    end
  end

  // a final beat starts the squeeze at the first digest word
  a_final_starts_squeeze: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tlast) |=> (squeezing && wcnt == '0))
    else $error("final beat did not start squeeze");

  // the last digest word ends the squeeze with the initial value reloaded
  a_last_reloads_iv: assert property (@(posedge clk) disable iff (rst)
    (sq_step && sq_last) |=> (!squeezing && st == INIT_STATE && m_tvalid && m_tlast))
    else $error("squeeze end did not reload initial value");

  // a word that is not the last keeps the squeeze going
  a_mid_word_not_last: assert property (@(posedge clk) disable iff (rst)
    (sq_step && !sq_last) |=> (squeezing && m_tvalid && !m_tlast))
    else $error("intermediate digest word flagged wrongly");

endmodule

// File: tb/tb.sv
// tb: self-checking bench for ascon_hash_sponge_top (hash sponge, stream ports)
// depends on ahs_pkg for the round count and digest length, and on the dut
// carries its own sponge predictor and checks every digest beat in order
`timescale 1ns / 100ps

module tb;

  localparam int RAND_BEATS  = 200;
  localparam int IDLE_PCT    = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT     = 100;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [63:0] lane_t;

  typedef struct packed {
    logic       fin;
    logic [2:0] nv;
    lane_t      blk;
  } msg_beat_t;

  typedef struct packed {
    logic  last;
    lane_t word;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;   // [63:0] block, [66:64] valid_bytes, zeros above
  logic        s_tlast  = 1'b0; // final_block
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // [63:0] digest_word
  logic        m_tlast;   // digest_last

  msg_beat_t    msg_q[$];
  digest_beat_t digest_q[$];
  lane_t        sponge[5];

  msg_beat_t    cur_beat;
  msg_beat_t    mon_beat;
  digest_beat_t got_beat;
  digest_beat_t exp_beat;
  int           total_beats;
  int           beats_sent   = 0;
  int           beats_taken  = 0;
  int           words_seen   = 0;
  int           err_count    = 0;
  int           stall_cycles = 0;
  int           hold_cnt     = 0;
  logic         held_off     = 1'b0;
  logic         in_fire      = 1'b0;

  ascon_hash_sponge_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // sponge predictor
  // ---------------------------------------------------------------------------

  function automatic lane_t ror64(lane_t v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic void load_iv();
    sponge[0] = 64'hee9398aadb67f03d;
    sponge[1] = 64'h8bb21831c60f1002;
    sponge[2] = 64'hb48a92db98d5da62;
    sponge[3] = 64'h43189921b8f8e3e8;
    sponge[4] = 64'h348fa5c9d525e140;
  endfunction

  // rounds 12-ROUND_COUNT .. 11 of the permutation on the sponge lanes
  function automatic void permute_sponge();
    lane_t a, b, c, d, e;
    lane_t t0, t1, t2, t3, t4;
    logic [3:0] rc;
    a = sponge[0]; b = sponge[1]; c = sponge[2]; d = sponge[3]; e = sponge[4];
    for (int r = 12 - ahs_pkg::ROUND_COUNT; r < 12; r++) begin
      rc = r[3:0];
      c  = c ^ {56'd0, 4'hf - rc, rc};
      // s-box layer
      a  = a ^ e; e = e ^ d; c = c ^ b;
      t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
      a  = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
      b  = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
      // linear diffusion
      a  = a ^ ror64(a, 19) ^ ror64(a, 28);
      b  = b ^ ror64(b, 61) ^ ror64(b, 39);
      c  = c ^ ror64(c, 1)  ^ ror64(c, 6);
      d  = d ^ ror64(d, 10) ^ ror64(d, 17);
      e  = e ^ ror64(e, 7)  ^ ror64(e, 41);
    end
    sponge[0] = a; sponge[1] = b; sponge[2] = c; sponge[3] = d; sponge[4] = e;
  endfunction

  // absorb one message block; a final block pads and queues the digest words
  function automatic void absorb_block(msg_beat_t mb);
    lane_t        keep;
    lane_t        pad;
    digest_beat_t db;
    if (!mb.fin) begin
      sponge[0] = sponge[0] ^ mb.blk;
      permute_sponge();
    end else begin
      keep = (mb.nv == 3'd0) ? 64'd0 : (~64'd0 << (64 - 8 * int'(mb.nv)));
      pad  = 64'h80 << (56 - 8 * int'(mb.nv));
      sponge[0] = sponge[0] ^ ((mb.blk & keep) | pad);
      permute_sponge();
      for (int k = 0; k < ahs_pkg::DIGEST_WORDS; k++) begin
        db.word = sponge[0];
        db.last = (k == ahs_pkg::DIGEST_WORDS - 1);
        digest_q.push_back(db);
        if (k != ahs_pkg::DIGEST_WORDS - 1) permute_sponge();
      end
      load_iv();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_beat(lane_t blk, logic fin, logic [2:0] nv);
    msg_beat_t mb;
    mb.blk = blk;
    mb.fin = fin;
    mb.nv  = nv;
    msg_q.push_back(mb);
  endfunction

  // mostly random words, now and then the extremes
  function automatic lane_t rand_block();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 64'd0;
    if (pick == 1) return ~64'd0;
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued beats, idles at random outside a quiet window
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (msg_q.size() != 0 &&
          ((beats_sent >= 60 && beats_sent < 110) || $urandom_range(99) >= IDLE_PCT)) begin
        cur_beat = msg_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cur_beat.nv, cur_beat.blk};
        s_tlast  <= cur_beat.fin;
        beats_sent <= beats_sent + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off to back up the input side
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
      held_off <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!held_off && words_seen >= HOLD_AT) begin
      m_tready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      held_off <= 1'b1;
    end else begin
      m_tready <= (words_seen >= 140 && words_seen < 200) ||
                  ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input beat, checks each digest beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (rst) load_iv();
    if (!rst && m_tvalid && m_tready) begin
      got_beat.word = m_tdata;
      got_beat.last = m_tlast;
      if (digest_q.size() == 0) begin
        $error("unexpected digest beat: digest_word %h digest_last %b",
               got_beat.word, got_beat.last);
        err_count++;
      end else begin
        exp_beat = digest_q.pop_front();
        if (got_beat.word !== exp_beat.word) begin
          $error("digest_word: expected %h, got %h", exp_beat.word, got_beat.word);
          err_count++;
        end
        if (got_beat.last !== exp_beat.last) begin
          $error("digest_last: expected %b, got %b", exp_beat.last, got_beat.last);
          err_count++;
        end
      end
      words_seen <= words_seen + 1;
    end
    // input beat after the output check, its digest cannot leave this cycle
    if (!rst && s_tvalid && s_tready) begin
      mon_beat.blk = s_tdata[63:0];
      mon_beat.nv  = s_tdata[66:64];
      mon_beat.fin = s_tlast;
      absorb_block(mon_beat);
      beats_taken <= beats_taken + 1;
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stim
    int n_body;
    int n_rand;

    // empty messages, the padding must override whatever the block holds
    add_beat(~64'd0, 1'b1, 3'd0);
    add_beat(64'd0, 1'b1, 3'd0);
    // one-block messages with every nonzero valid count, ignored bytes all ones
    for (int v = 1; v < 8; v++) add_beat(~64'd0, 1'b1, v[2:0]);
    // valid_bytes on a non-final block has no effect
    add_beat(64'd0, 1'b0, 3'd7);
    add_beat(~64'd0, 1'b0, 3'd0);
    add_beat(64'd0, 1'b1, 3'd7);
    add_beat(rand_block(), 1'b0, 3'd5);
    add_beat(~64'd0, 1'b0, 3'd7);
    add_beat(64'h0123456789abcdef, 1'b0, 3'd2);
    add_beat({$urandom, $urandom}, 1'b1, 3'd3);

    // random messages, a few long ones
    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      n_body = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(5);
      for (int i = 0; i < n_body; i++) add_beat(rand_block(), 1'b0, 3'($urandom_range(7)));
      add_beat(rand_block(), 1'b1, 3'($urandom_range(7)));
      n_rand += n_body + 1;
    end
    total_beats = msg_q.size();

    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (beats_taken != total_beats || digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
